### design/sdm_pkg.sv
`timescale 1ns / 1ps
// sdm_pkg: shared widths and codes for the diagonal-format sparse matvec block
// no dependencies; imported by sdm_mac and sparse_dia_matvec
package sdm_pkg;

    // operand and accumulator widths (Q16.16 operands, Q32.32 accumulator)
    localparam int OPND_W = 32;
    localparam int ACC_W  = 64;

    // input field widths
    localparam int ACTION_W = 3;
    localparam int SEL_W    = 4;
    localparam int POS_W    = 10;
    localparam int OFF_W    = 11;
    localparam int STATUS_W = 2;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int ROWS_W     = 11;
    localparam int DIAGS_W    = 5;
    localparam int STRIDE_W   = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIAG_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIAG_STRIDE = 2'd2;

    localparam logic [ROWS_W-1:0]   ROWS_RESET   = 11'd1024;
    localparam logic [DIAGS_W-1:0]  DIAGS_RESET  = 5'd1;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 11'd1024;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_LOAD_OFF = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_VAL = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_LOAD_X   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_LOAD_Y   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_COMPUTE  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_READ_Y   = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SKIP  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SAT   = 2'd3;

endpackage

### design/sparse_dia_matvec.sv
`timescale 1ns / 1ps
// sparse_dia_matvec: diagonal-format sparse matrix-vector multiply-accumulate
// depends on sdm_pkg and sdm_mac; holds the offset, value, x and y memories
//
//   channel  signals                                   direction
//   in       in_valid in_stall action .. y_init        into block
//   out      out_valid out_stall y_value status        out of block
//   cfg      cfg_wr_en cfg_index cfg_data              into block
//
// loads answer from S_IDLE; a y read goes via S_RDATA (memory reads are registered)
// compute: per diagonal S_SETUP, then per row S_TERM, S_MUL, S_ADD for a term
//   (read, multiply, add and write back of y) or S_TERM alone for a skipped row
// terms run one at a time, so the y read-modify-write never overlaps
// reset initialises control and config only; memories are undefined until loaded
// in_stall is high while a transaction is in progress or the result is stalled
module sparse_dia_matvec
    import sdm_pkg::*;
#(
    parameter int MAX_ROWS   = 1024,
    parameter int MAX_DIAGS  = 16,
    parameter int MAX_STRIDE = 1024
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [ACTION_W-1:0]        action,
    input  logic [SEL_W-1:0]           diag_sel,
    input  logic [POS_W-1:0]           position,
    input  logic signed [OFF_W-1:0]    diag_offset,
    input  logic signed [OPND_W-1:0]   elem_value,
    input  logic signed [ACC_W-1:0]    y_init,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [ACC_W-1:0]    y_value,
    output logic [STATUS_W-1:0]        status,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    localparam int RW   = $clog2(MAX_ROWS + 1);
    localparam int SDW  = $clog2(MAX_STRIDE + 1);
    localparam int DCW  = $clog2(MAX_DIAGS + 1);
    localparam int DA   = (MAX_DIAGS > 1) ? $clog2(MAX_DIAGS) : 1;
    localparam int XA   = $clog2(MAX_ROWS);
    localparam int VDEP = MAX_DIAGS * MAX_STRIDE;
    localparam int VA   = $clog2(VDEP);
    localparam int MW   = (RW > SDW) ? RW : SDW;
    localparam int CW   = ((MW > OFF_W) ? MW : OFF_W) + 2;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RDATA = 6'b000010,
        S_SETUP = 6'b000100,
        S_TERM  = 6'b001000,
        S_MUL   = 6'b010000,
        S_ADD   = 6'b100000
    } state_t;

    // memories
    logic signed [OFF_W-1:0]  off_mem [MAX_DIAGS];
    logic signed [OPND_W-1:0] val_mem [VDEP];
    logic signed [OPND_W-1:0] x_mem   [MAX_ROWS];
    logic signed [ACC_W-1:0]  y_mem   [MAX_ROWS];

    logic                     off_we, off_re, val_we, val_re, x_we, x_re, y_we, y_re;
    logic [DA-1:0]            off_waddr, off_raddr;
    logic [VA-1:0]            val_waddr, val_raddr;
    logic [XA-1:0]            x_waddr, x_raddr, y_waddr, y_raddr;
    logic signed [ACC_W-1:0]  y_wdata;
    logic signed [OFF_W-1:0]  off_rdata;
    logic signed [OPND_W-1:0] val_rdata, x_rdata;
    logic signed [ACC_W-1:0]  y_rdata;

    // configuration registers and clamped values
    logic [ROWS_W-1:0]   row_count_reg;
    logic [DIAGS_W-1:0]  diag_count_reg;
    logic [STRIDE_W-1:0] diag_stride_reg;
    logic [RW-1:0]       rows_eff;
    logic [DCW-1:0]      nd_eff;
    logic [SDW-1:0]      stride_eff;

    // control state
    state_t                  state_reg, state_next;
    logic [DCW-1:0]          i_reg, i_next;
    logic signed [CW-1:0]    n_reg, n_next, hi_reg, hi_next;
    logic signed [CW-1:0]    base_reg, base_next, k_reg, k_next;
    logic [VA-1:0]           vbase_reg, vbase_next;
    logic                    skip_reg, skip_next, sat_reg, sat_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [ACC_W-1:0] y_value_reg, y_value_next;
    logic [STATUS_W-1:0]     status_reg, status_next;

    logic                    accept, out_take, mac_load, mac_sat;
    logic signed [ACC_W-1:0] mac_sum;

    // clamp configuration to its legal range
    always_comb
    begin
        if (row_count_reg == '0)
            rows_eff = RW'(1);
        else if (32'(row_count_reg) > MAX_ROWS)
            rows_eff = RW'(MAX_ROWS);
        else
            rows_eff = RW'(row_count_reg);

        if (diag_count_reg == '0)
            nd_eff = DCW'(1);
        else if (32'(diag_count_reg) > MAX_DIAGS)
            nd_eff = DCW'(MAX_DIAGS);
        else
            nd_eff = DCW'(diag_count_reg);

        if (diag_stride_reg == '0)
            stride_eff = SDW'(1);
        else if (32'(diag_stride_reg) > MAX_STRIDE)
            stride_eff = SDW'(MAX_STRIDE);
        else
            stride_eff = SDW'(diag_stride_reg);
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg   <= ROWS_RESET;
            diag_count_reg  <= DIAGS_RESET;
            diag_stride_reg <= STRIDE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_ROW_COUNT:   row_count_reg   <= cfg_data[ROWS_W-1:0];
                CFG_DIAG_COUNT:  diag_count_reg  <= cfg_data[DIAGS_W-1:0];
                CFG_DIAG_STRIDE: diag_stride_reg <= cfg_data[STRIDE_W-1:0];
                default:         ;
            endcase
        end
    end

    // handshake
    assign out_take = out_valid_reg && !out_stall;
    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    // sequencer
    always_comb
    begin
        logic                 do_adv, do_diag, do_done;
        logic [7:0]           sel8;
        logic signed [CW-1:0] k_s, rows_s, stride_s, lo_s, hi_s, j_s;

        do_adv   = 1'b0;
        do_diag  = 1'b0;
        do_done  = 1'b0;
        sel8     = {4'b0, diag_sel};
        rows_s   = $signed({{(CW-RW){1'b0}}, rows_eff});
        stride_s = $signed({{(CW-SDW){1'b0}}, stride_eff});
        k_s      = $signed({{(CW-OFF_W){off_rdata[OFF_W-1]}}, off_rdata});
        lo_s     = (k_s < 0) ? -k_s : '0;
        hi_s     = (k_s > 0) ? rows_s - CW'(1) - k_s : rows_s - CW'(1);
        j_s      = n_reg - base_reg;

        state_next     = state_reg;
        i_next         = i_reg;
        n_next         = n_reg;
        hi_next        = hi_reg;
        base_next      = base_reg;
        k_next         = k_reg;
        vbase_next     = vbase_reg;
        skip_next      = skip_reg;
        sat_next       = sat_reg;
        out_valid_next = out_take ? 1'b0 : out_valid_reg;
        y_value_next   = y_value_reg;
        status_next    = status_reg;

        off_we    = 1'b0;
        off_waddr = sel8[DA-1:0];
        off_re    = 1'b0;
        off_raddr = i_reg[DA-1:0];
        val_we    = 1'b0;
        val_waddr = VA'(32'(diag_sel) * MAX_STRIDE + 32'(position));
        val_re    = 1'b0;
        val_raddr = vbase_reg + VA'(j_s);
        x_we      = 1'b0;
        x_waddr   = XA'(32'(position));
        x_re      = 1'b0;
        x_raddr   = XA'(n_reg + k_reg);
        y_we      = 1'b0;
        y_waddr   = XA'(n_reg);
        y_wdata   = mac_sum;
        y_re      = 1'b0;
        y_raddr   = XA'(n_reg);
        mac_load  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    y_value_next = '0;
                    status_next  = ST_OK;
                    unique case (action)
                        ACT_LOAD_OFF:
                        begin
                            out_valid_next = 1'b1;
                            if (sel8 < 8'(nd_eff))
                                off_we = 1'b1;
                            else
                                status_next = ST_RANGE;
                        end
                        ACT_LOAD_VAL:
                        begin
                            out_valid_next = 1'b1;
                            if (sel8 < 8'(nd_eff) && 32'(position) < 32'(stride_eff))
                                val_we = 1'b1;
                            else
                                status_next = ST_RANGE;
                        end
                        ACT_LOAD_X:
                        begin
                            out_valid_next = 1'b1;
                            if (32'(position) < 32'(rows_eff))
                                x_we = 1'b1;
                            else
                                status_next = ST_RANGE;
                        end
                        ACT_LOAD_Y:
                        begin
                            out_valid_next = 1'b1;
                            y_waddr = XA'(32'(position));
                            y_wdata = y_init;
                            if (32'(position) < 32'(rows_eff))
                                y_we = 1'b1;
                            else
                                status_next = ST_RANGE;
                        end
                        ACT_COMPUTE:
                        begin
                            out_valid_next = 1'b0;
                            i_next     = '0;
                            vbase_next = '0;
                            skip_next  = 1'b0;
                            sat_next   = 1'b0;
                            off_re     = 1'b1;
                            off_raddr  = '0;
                            state_next = S_SETUP;
                        end
                        ACT_READ_Y:
                        begin
                            y_raddr = XA'(32'(position));
                            if (32'(position) < 32'(rows_eff))
                            begin
                                out_valid_next = 1'b0;
                                y_re       = 1'b1;
                                state_next = S_RDATA;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                                status_next    = ST_RANGE;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_RDATA:
            begin
                out_valid_next = 1'b1;
                y_value_next   = y_rdata;
                status_next    = ST_OK;
                state_next     = S_IDLE;
            end
            S_SETUP:
            begin
                k_next    = k_s;
                hi_next   = hi_s;
                n_next    = lo_s;
                base_next = (k_s < 0) ? rows_s - stride_s : '0;
                if (lo_s > hi_s)
                    do_diag = 1'b1;
                else
                    state_next = S_TERM;
            end
            S_TERM:
            begin
                if (j_s < 0 || j_s >= stride_s)
                begin
                    skip_next = 1'b1;
                    do_adv    = 1'b1;
                end
                else
                begin
                    val_re     = 1'b1;
                    x_re       = 1'b1;
                    y_re       = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                mac_load   = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                y_we = 1'b1;
                if (mac_sat)
                    sat_next = 1'b1;
                do_adv = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // next row, or next diagonal at the end of this one
        if (do_adv)
        begin
            if (n_reg == hi_reg)
            begin
                do_diag = 1'b1;
            end
            else
            begin
                n_next     = n_reg + CW'(1);
                state_next = S_TERM;
            end
        end

        // next diagonal, or finish
        if (do_diag)
        begin
            if (i_reg + DCW'(1) == nd_eff)
            begin
                do_done = 1'b1;
            end
            else
            begin
                i_next     = i_reg + DCW'(1);
                vbase_next = vbase_reg + VA'(MAX_STRIDE);
                off_re     = 1'b1;
                off_raddr  = i_next[DA-1:0];
                state_next = S_SETUP;
            end
        end

        // compute transaction result
        if (do_done)
        begin
            out_valid_next = 1'b1;
            y_value_next   = '0;
            status_next    = sat_next ? ST_SAT : (skip_next ? ST_SKIP : ST_OK);
            state_next     = S_IDLE;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            n_reg         <= '0;
            hi_reg        <= '0;
            base_reg      <= '0;
            k_reg         <= '0;
            vbase_reg     <= '0;
            skip_reg      <= 1'b0;
            sat_reg       <= 1'b0;
            y_value_reg   <= '0;
            status_reg    <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            i_reg         <= i_next;
            n_reg         <= n_next;
            hi_reg        <= hi_next;
            base_reg      <= base_next;
            k_reg         <= k_next;
            vbase_reg     <= vbase_next;
            skip_reg      <= skip_next;
            sat_reg       <= sat_next;
            y_value_reg   <= y_value_next;
            status_reg    <= status_next;
        end
    end

    // offset memory
    always_ff @(posedge clk)
    begin
        if (off_we)
            off_mem[off_waddr] <= diag_offset;
        if (off_re)
            off_rdata <= off_mem[off_raddr];
    end

    // diagonal value memory
    always_ff @(posedge clk)
    begin
        if (val_we)
            val_mem[val_waddr] <= elem_value;
        if (val_re)
            val_rdata <= val_mem[val_raddr];
    end

    // x vector memory
    always_ff @(posedge clk)
    begin
        if (x_we)
            x_mem[x_waddr] <= elem_value;
        if (x_re)
            x_rdata <= x_mem[x_raddr];
    end

    // y vector memory
    always_ff @(posedge clk)
    begin
        if (y_we)
            y_mem[y_waddr] <= y_wdata;
        if (y_re)
            y_rdata <= y_mem[y_raddr];
    end

    // multiply-accumulate unit
    sdm_mac u_mac (
        .clk    (clk),
        .load   (mac_load),
        .opnd_a (val_rdata),
        .opnd_b (x_rdata),
        .acc    (y_rdata),
        .sum    (mac_sum),
        .sat    (mac_sat)
    );

    assign out_valid = out_valid_reg;
    assign y_value   = y_value_reg;
    assign status    = status_reg;

endmodule

### design/sdm_mac.sv
`timescale 1ns / 1ps
// sdm_mac: registered Q16.16 x Q16.16 product and saturating Q32.32 accumulate
// depends on sdm_pkg for operand and accumulator widths
module sdm_mac
    import sdm_pkg::*;
(
    input  logic                     clk,
    input  logic                     load,
    input  logic signed [OPND_W-1:0] opnd_a,
    input  logic signed [OPND_W-1:0] opnd_b,
    input  logic signed [ACC_W-1:0]  acc,
    output logic signed [ACC_W-1:0]  sum,
    output logic                     sat
);

    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W:0]   wide_sum;

    // exact product, registered before the add
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= ACC_W'(opnd_a * opnd_b);
        end
    end

    // saturating accumulate
    always_comb
    begin
        wide_sum = {acc[ACC_W-1], acc} + {prod_reg[ACC_W-1], prod_reg};
        sat = (wide_sum[ACC_W] != wide_sum[ACC_W-1]);
        if (!sat)
        begin
            sum = wide_sum[ACC_W-1:0];
        end
        else if (wide_sum[ACC_W])
        begin
            sum = {1'b1, {(ACC_W-1){1'b0}}};
        end
        else
        begin
            sum = {1'b0, {(ACC_W-1){1'b1}}};
        end
    end

endmodule
